// ===== hw/rtl/cfbu_pkg.sv =====
// ----------------------------------------------------------------------------
// cfbu_pkg: shared types, codes and helpers of the correlation filter bin engine
// Action codes, register indexes, reset values, saturation helpers and one
// step of the restoring divider that forms the filter quotient.
// ----------------------------------------------------------------------------
`default_nettype none

package cfbu_pkg;

	typedef enum logic [1:0] {
		ACT_TRAIN_FIRST = 2'd0,
		ACT_TRAIN_ADD   = 2'd1,
		ACT_TRACK       = 2'd2,
		ACT_CORRELATE   = 2'd3
	} action_t;

	// register index as seen on paddr[2]
	localparam logic REG_IDX_LR  = 1'b0;
	localparam logic REG_IDX_REG = 1'b1;

	localparam logic [16:0] LR_RESET  = 17'd8192;
	localparam logic [31:0] REG_RESET = 32'd6554;
	localparam logic [16:0] ONE_Q16   = 17'h10000;

	localparam int DIV_BITS = 32;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

	// one divider lane: partial remainder, quotient so far, dividend bits left
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] quo;
		logic [15:0] mlo;
		logic        neg;
		logic        ovf;
		logic        zero;
	} div_lane_t;

	typedef struct packed {
		logic [31:0] h;
		logic        clip;
	} lane_res_t;

	function automatic logic ovf_s65(input logic signed [64:0] x);
		return x[64] ^ x[63];
	endfunction

	function automatic logic signed [63:0] sat_s64(input logic signed [64:0] x);
		logic signed [63:0] r;
		r = x[63:0];
		if (x[64] != x[63]) begin
			r = x[64] ? S64_MIN : S64_MAX;
		end
		return r;
	endfunction

	function automatic logic ovf_s49(input logic signed [48:0] x);
		return x[48] ^ x[47];
	endfunction

	function automatic logic signed [47:0] sat_s48(input logic signed [48:0] x);
		logic signed [47:0] r;
		r = x[47:0];
		if (x[48] != x[47]) begin
			r = x[48] ? S48_MIN : S48_MAX;
		end
		return r;
	endfunction

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic div_lane_t div_step(input div_lane_t l, input logic [63:0] d);
		div_lane_t   r;
		logic [64:0] t;
		logic        ge;
		r  = l;
		t  = {l.rem, l.mlo[15]};
		ge = (t >= {1'b0, d});
		if (ge) begin
			t = t - {1'b0, d};
		end
		r.rem = t[63:0];
		r.quo = {l.quo[30:0], ge};
		r.mlo = {l.mlo[14:0], 1'b0};
		return r;
	endfunction

	// sign and saturation of a finished lane
	function automatic lane_res_t lane_finish(input div_lane_t l);
		lane_res_t   r;
		logic [31:0] lim;
		logic [31:0] q;
		lim    = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		q      = l.quo;
		r.clip = 1'b0;
		if (l.zero) begin
			q = '0;
		end else if (l.ovf || (l.quo > lim)) begin
			q      = lim;
			r.clip = 1'b1;
		end
		r.h = l.neg ? (32'd0 - q) : q;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/correlation_filter_bin_update.sv =====
// ----------------------------------------------------------------------------
// correlation_filter_bin_update: per-bin correlation filter update engine
// Keeps numerator, denominator and filter per frequency bin; trains, blends,
// divides and answers each bin with the correlation response.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one bin beat per cycle: action,
// bin_index, frame and goal spectrum values. Output channel (out_valid/
// out_ready) returns one beat per input beat, in order: the response of the
// frame against the filter held before the beat, the filter after the beat
// and a saturation flag.
// Between input and output lie six arithmetic stages, a 33-stage divider pipe
// (an entry stage, then one quotient bit per stage, two lanes) and the output
// register. Throughput is one beat per cycle while the output flows; a beat
// whose bin is still being updated further down the pipe waits at the input
// until that update is written back.
// After reset the filter store is cleared one bin per cycle, with in_ready
// low; the APB port works during that time.
// When out_ready is low while out_valid is high, the whole pipe holds and
// in_ready drops; nothing is lost or repeated. The user must write registers
// over APB only while idle; the block itself does not enforce this.
`default_nettype none

module correlation_filter_bin_update #(
	parameter int NUM_BINS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [11:0]        bin_index,
	input  logic signed [31:0] frame_re,
	input  logic signed [31:0] frame_im,
	input  logic signed [31:0] goal_re,
	input  logic signed [31:0] goal_im,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        out_bin,
	output logic signed [47:0] response_re,
	output logic signed [47:0] response_im,
	output logic signed [31:0] filter_out_re,
	output logic signed [31:0] filter_out_im,
	output logic               clipped
);
	import cfbu_pkg::*;

	localparam int AW = $clog2(NUM_BINS);

	typedef struct packed {
		action_t        act;
		logic [11:0]    bin;
		logic [AW-1:0]  addr;
		logic           rng;
		logic           wr;
	} ctl_t;

	typedef struct packed {
		ctl_t               c;
		logic signed [47:0] rr;
		logic signed [47:0] ri;
		logic signed [31:0] hre;
		logic signed [31:0] him;
		logic signed [63:0] are;
		logic signed [63:0] aim;
		logic [63:0]        b;
		logic [63:0]        d;
		logic               clip;
		div_lane_t          lre;
		div_lane_t          lim;
	} dstage_t;

	// ---------------- configuration ----------------
	logic [16:0] lr_q;
	logic [31:0] reg_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_IDX_LR) ? {15'd0, lr_q} : reg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RESET;
			reg_q <= REG_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_IDX_LR) begin
				lr_q <= pwdata[16:0];
			end else begin
				reg_q <= pwdata;
			end
		end
	end

	// ---------------- clearing pass ----------------
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(NUM_BINS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// ---------------- stores ----------------
	logic signed [63:0] numer_re_mem [NUM_BINS];
	logic signed [63:0] numer_im_mem [NUM_BINS];
	logic [63:0]        denom_mem    [NUM_BINS];
	logic signed [31:0] held_re_mem  [NUM_BINS];
	logic signed [31:0] held_im_mem  [NUM_BINS];

	// ---------------- pipeline control ----------------
	logic          adv;
	logic          haz;
	logic          acc;
	logic [16:0]   bin_ext;
	logic          in_rng;
	logic [AW-1:0] addr_in;
	ctl_t          ctl_in;

	logic    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s40;
	ctl_t    ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	dstage_t div_s   [DIV_BITS+1];
	logic    div_v_s [DIV_BITS+1];
	logic    wb_en;

	assign adv     = !v_s40 || out_ready;
	assign bin_ext = 17'(bin_index);
	assign in_rng  = bin_ext < 17'(NUM_BINS);
	assign addr_in = in_rng ? bin_ext[AW-1:0] : '0;
	assign in_ready = adv && !clr_q && !haz;
	assign acc     = in_valid && in_ready;

	always_comb begin
		ctl_in.act  = action_t'(action);
		ctl_in.bin  = bin_index;
		ctl_in.addr = addr_in;
		ctl_in.rng  = in_rng;
		ctl_in.wr   = in_rng && (action_t'(action) != ACT_CORRELATE);
	end

	// a beat may not read a bin whose update is still in flight
	always_comb begin
		haz = (v_s1 && ctl_s1.wr && ctl_s1.addr == addr_in)
			|| (v_s2 && ctl_s2.wr && ctl_s2.addr == addr_in)
			|| (v_s3 && ctl_s3.wr && ctl_s3.addr == addr_in)
			|| (v_s4 && ctl_s4.wr && ctl_s4.addr == addr_in)
			|| (v_s5 && ctl_s5.wr && ctl_s5.addr == addr_in)
			|| (v_s6 && ctl_s6.wr && ctl_s6.addr == addr_in);
		for (int k = 0; k <= DIV_BITS; k++) begin
			if (div_v_s[k] && div_s[k].c.wr && div_s[k].c.addr == addr_in) begin
				haz = 1'b1;
			end
		end
		haz = haz && in_rng;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s40 <= 1'b0;
			for (int k = 0; k <= DIV_BITS; k++) begin
				div_v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			div_v_s[0] <= v_s6;
			for (int k = 1; k <= DIV_BITS; k++) begin
				div_v_s[k] <= div_v_s[k-1];
			end
			v_s40 <= div_v_s[DIV_BITS];
		end
	end

	// ---------------- stage 1: inputs and store read ----------------
	logic signed [31:0] fr_s1, fi_s1, gr_s1, gi_s1;
	logic signed [63:0] nre_s1, nim_s1;
	logic [63:0]        den_s1;
	logic signed [31:0] hre_s1, him_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			fr_s1  <= frame_re;
			fi_s1  <= frame_im;
			gr_s1  <= goal_re;
			gi_s1  <= goal_im;
			nre_s1 <= numer_re_mem[addr_in];
			nim_s1 <= numer_im_mem[addr_in];
			den_s1 <= denom_mem[addr_in];
			hre_s1 <= held_re_mem[addr_in];
			him_s1 <= held_im_mem[addr_in];
		end
	end

	// ---------------- stage 2: products ----------------
	// 0 gr*fr, 1 gi*fi, 2 gi*fr, 3 gr*fi, 4 fr*fr, 5 fi*fi,
	// 6 fr*hr, 7 fi*hi, 8 fr*hi, 9 fi*hr
	logic signed [63:0] p_s2 [10];
	logic signed [63:0] nre_s2, nim_s2;
	logic [63:0]        den_s2;
	logic signed [31:0] hre_s2, him_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			p_s2[0] <= gr_s1 * fr_s1;
			p_s2[1] <= gi_s1 * fi_s1;
			p_s2[2] <= gi_s1 * fr_s1;
			p_s2[3] <= gr_s1 * fi_s1;
			p_s2[4] <= fr_s1 * fr_s1;
			p_s2[5] <= fi_s1 * fi_s1;
			p_s2[6] <= fr_s1 * hre_s1;
			p_s2[7] <= fi_s1 * him_s1;
			p_s2[8] <= fr_s1 * him_s1;
			p_s2[9] <= fi_s1 * hre_s1;
			nre_s2  <= nre_s1;
			nim_s2  <= nim_s1;
			den_s2  <= den_s1;
			hre_s2  <= hre_s1;
			him_s2  <= him_s1;
		end
	end

	// ---------------- stage 3: instance terms and response ----------------
	logic signed [64:0] ar65, ai65, rr65, ri65;
	logic [63:0]        bd_c;
	logic               clip2_c;

	always_comb begin
		ar65 = 65'(p_s2[0]) + 65'(p_s2[1]);
		ai65 = 65'(p_s2[2]) - 65'(p_s2[3]);
		bd_c = $unsigned(p_s2[4]) + $unsigned(p_s2[5]);
		rr65 = 65'(p_s2[6]) - 65'(p_s2[7]);
		ri65 = 65'(p_s2[8]) + 65'(p_s2[9]);
		clip2_c = ovf_s49(rr65[64:16]) || ovf_s49(ri65[64:16])
			|| ((ctl_s2.act != ACT_CORRELATE) && (ovf_s65(ar65) || ovf_s65(ai65)));
	end

	logic signed [63:0] ar_s3, ai_s3, nre_s3, nim_s3;
	logic [63:0]        bd_s3, den_s3;
	logic signed [47:0] rr_s3, ri_s3;
	logic signed [31:0] hre_s3, him_s3;
	logic               clip_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3  <= ctl_s2;
			ar_s3   <= sat_s64(ar65);
			ai_s3   <= sat_s64(ai65);
			bd_s3   <= bd_c;
			rr_s3   <= sat_s48(rr65[64:16]);
			ri_s3   <= sat_s48(ri65[64:16]);
			clip_s3 <= clip2_c;
			nre_s3  <= nre_s2;
			nim_s3  <= nim_s2;
			den_s3  <= den_s2;
			hre_s3  <= hre_s2;
			him_s3  <= him_s2;
		end
	end

	// ---------------- stage 4: sums and blend partial products ----------------
	// lanes 0 numerator real, 1 numerator imaginary, 2 denominator
	logic [16:0]        wq, wc;
	logic signed [64:0] old_x [3];
	logic signed [64:0] new_x [3];
	logic signed [64:0] sum_x [3];
	logic [64:0]        den_sum;
	logic               clip3_c;

	always_comb begin
		wq = lr_q[16] ? ONE_Q16 : lr_q;
		wc = ONE_Q16 - wq;
		old_x[0] = 65'(nre_s3);
		old_x[1] = 65'(nim_s3);
		old_x[2] = $signed({1'b0, den_s3});
		new_x[0] = 65'(ar_s3);
		new_x[1] = 65'(ai_s3);
		new_x[2] = $signed({1'b0, bd_s3});
		for (int i = 0; i < 3; i++) begin
			sum_x[i] = old_x[i] + new_x[i];
		end
		den_sum = {1'b0, den_s3} + {1'b0, bd_s3};
		clip3_c = clip_s3 || ((ctl_s3.act == ACT_TRAIN_ADD)
			&& (ovf_s65(sum_x[0]) || ovf_s65(sum_x[1]) || den_sum[64]));
	end

	logic signed [50:0] ph_o_s4 [3];
	logic signed [50:0] ph_i_s4 [3];
	logic [48:0]        pl_o_s4 [3];
	logic [48:0]        pl_i_s4 [3];
	logic [63:0]        add_s4  [3];
	logic [63:0]        inst_s4 [3];
	logic signed [47:0] rr_s4, ri_s4;
	logic signed [31:0] hre_s4, him_s4;
	logic               clip_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			for (int i = 0; i < 3; i++) begin
				ph_o_s4[i] <= $signed(old_x[i][64:32]) * $signed({1'b0, wc});
				ph_i_s4[i] <= $signed(new_x[i][64:32]) * $signed({1'b0, wq});
				pl_o_s4[i] <= old_x[i][31:0] * wc;
				pl_i_s4[i] <= new_x[i][31:0] * wq;
				inst_s4[i] <= new_x[i][63:0];
			end
			add_s4[0] <= sat_s64(sum_x[0]);
			add_s4[1] <= sat_s64(sum_x[1]);
			add_s4[2] <= den_sum[64] ? '1 : den_sum[63:0];
			rr_s4   <= rr_s3;
			ri_s4   <= ri_s3;
			hre_s4  <= hre_s3;
			him_s4  <= him_s3;
			clip_s4 <= clip3_c;
		end
	end

	// ---------------- stage 5: blend sum and action select ----------------
	logic signed [51:0] ph_sum [3];
	logic [49:0]        pl_sum [3];
	logic signed [84:0] tot    [3];
	logic [63:0]        sel_x  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ph_sum[i] = 52'(ph_o_s4[i]) + 52'(ph_i_s4[i]);
			pl_sum[i] = 50'(pl_o_s4[i]) + 50'(pl_i_s4[i]);
			tot[i] = $signed({ph_sum[i][51], ph_sum[i], 32'd0})
				+ $signed({35'd0, pl_sum[i]});
			case (ctl_s4.act)
				ACT_TRAIN_FIRST: sel_x[i] = inst_s4[i];
				ACT_TRAIN_ADD:   sel_x[i] = add_s4[i];
				ACT_TRACK:       sel_x[i] = tot[i][79:16];
				default:         sel_x[i] = inst_s4[i];
			endcase
		end
	end

	logic signed [63:0] are_s5, aim_s5;
	logic [63:0]        b_s5;
	logic signed [47:0] rr_s5, ri_s5;
	logic signed [31:0] hre_s5, him_s5;
	logic               clip_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5  <= ctl_s4;
			are_s5  <= sel_x[0];
			aim_s5  <= sel_x[1];
			b_s5    <= sel_x[2];
			rr_s5   <= rr_s4;
			ri_s5   <= ri_s4;
			hre_s5  <= hre_s4;
			him_s5  <= him_s4;
			clip_s5 <= clip_s4;
		end
	end

	// ---------------- stage 6: divisor and magnitudes ----------------
	logic [64:0] d65;

	assign d65 = {1'b0, b_s5} + {33'd0, reg_q};

	logic signed [63:0] are_s6, aim_s6;
	logic [63:0]        b_s6, d_s6, mre_s6, mim_s6;
	logic signed [47:0] rr_s6, ri_s6;
	logic signed [31:0] hre_s6, him_s6;
	logic               clip_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6  <= ctl_s5;
			are_s6  <= are_s5;
			aim_s6  <= aim_s5;
			b_s6    <= b_s5;
			d_s6    <= d65[64] ? '1 : d65[63:0];
			mre_s6  <= are_s5[63] ? (64'd0 - $unsigned(are_s5)) : $unsigned(are_s5);
			mim_s6  <= aim_s5[63] ? (64'd0 - $unsigned(aim_s5)) : $unsigned(aim_s5);
			rr_s6   <= rr_s5;
			ri_s6   <= ri_s5;
			hre_s6  <= hre_s5;
			him_s6  <= him_s5;
			clip_s6 <= clip_s5 || ((ctl_s5.act != ACT_CORRELATE) && d65[64]);
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	dstage_t div_in;

	always_comb begin
		div_in.c    = ctl_s6;
		div_in.rr   = rr_s6;
		div_in.ri   = ri_s6;
		div_in.hre  = hre_s6;
		div_in.him  = him_s6;
		div_in.are  = are_s6;
		div_in.aim  = aim_s6;
		div_in.b    = b_s6;
		div_in.d    = d_s6;
		div_in.clip = clip_s6;
		// quotient must stay below 2^32: overflow when m / 2^16 >= d
		div_in.lre.rem  = {16'd0, mre_s6[63:16]};
		div_in.lre.quo  = '0;
		div_in.lre.mlo  = mre_s6[15:0];
		div_in.lre.neg  = are_s6[63];
		div_in.lre.zero = (mre_s6 == 64'd0);
		div_in.lre.ovf  = ({16'd0, mre_s6[63:16]} >= d_s6) && (mre_s6 != 64'd0);
		div_in.lim.rem  = {16'd0, mim_s6[63:16]};
		div_in.lim.quo  = '0;
		div_in.lim.mlo  = mim_s6[15:0];
		div_in.lim.neg  = aim_s6[63];
		div_in.lim.zero = (mim_s6 == 64'd0);
		div_in.lim.ovf  = ({16'd0, mim_s6[63:16]} >= d_s6) && (mim_s6 != 64'd0);
	end

	dstage_t div_nx [DIV_BITS+1];

	always_comb begin
		div_nx[0] = div_in;
		for (int k = 1; k <= DIV_BITS; k++) begin
			div_nx[k]     = div_s[k-1];
			div_nx[k].lre = div_step(div_s[k-1].lre, div_s[k-1].d);
			div_nx[k].lim = div_step(div_s[k-1].lim, div_s[k-1].d);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= DIV_BITS; k++) begin
				div_s[k] <= div_nx[k];
			end
		end
	end

	// ---------------- final stage: sign, saturate, write back ----------------
	dstage_t            fin;
	lane_res_t          res_re, res_im;
	logic signed [31:0] h_re, h_im;
	logic               clip_f;

	always_comb begin
		fin    = div_s[DIV_BITS];
		res_re = lane_finish(fin.lre);
		res_im = lane_finish(fin.lim);
		if (fin.c.act == ACT_CORRELATE) begin
			h_re   = fin.hre;
			h_im   = fin.him;
			clip_f = fin.clip;
		end else begin
			h_re   = res_re.h;
			h_im   = res_im.h;
			clip_f = fin.clip || res_re.clip || res_im.clip;
		end
	end

	assign wb_en = adv && div_v_s[DIV_BITS] && fin.c.wr;

	always_ff @(posedge clk) begin
		if (wb_en) begin
			numer_re_mem[fin.c.addr] <= fin.are;
			numer_im_mem[fin.c.addr] <= fin.aim;
			denom_mem[fin.c.addr]    <= fin.b;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			held_re_mem[clr_idx_q] <= '0;
			held_im_mem[clr_idx_q] <= '0;
		end else if (wb_en) begin
			held_re_mem[fin.c.addr] <= h_re;
			held_im_mem[fin.c.addr] <= h_im;
		end
	end

	logic [11:0]        bin_s40;
	logic signed [47:0] rr_s40, ri_s40;
	logic signed [31:0] hre_s40, him_s40;
	logic               clip_s40;

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s40  <= fin.c.bin;
			rr_s40   <= fin.c.rng ? fin.rr : '0;
			ri_s40   <= fin.c.rng ? fin.ri : '0;
			hre_s40  <= fin.c.rng ? h_re : '0;
			him_s40  <= fin.c.rng ? h_im : '0;
			clip_s40 <= fin.c.rng && clip_f;
		end
	end

	assign out_valid     = v_s40;
	assign out_bin       = bin_s40;
	assign response_re   = rr_s40;
	assign response_im   = ri_s40;
	assign filter_out_re = hre_s40;
	assign filter_out_im = him_s40;
	assign clipped       = clip_s40;

endmodule

`default_nettype wire

// ===== hw/rtl/cfbu_checker.sv =====
// ----------------------------------------------------------------------------
// cfbu_checker: port-level checks of the correlation filter bin engine
// Watches the top level's ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbu_checker #(
	parameter int NUM_BINS = 4096
) (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         action,
	input logic [11:0]        bin_index,
	input logic signed [31:0] frame_re,
	input logic signed [31:0] frame_im,
	input logic signed [31:0] goal_re,
	input logic signed [31:0] goal_im,
	input logic               out_valid,
	input logic               out_ready,
	input logic [11:0]        out_bin,
	input logic signed [47:0] response_re,
	input logic signed [47:0] response_im,
	input logic signed [31:0] filter_out_re,
	input logic signed [31:0] filter_out_im,
	input logic               clipped
);
	import cfbu_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bin)
			&& $stable(response_re) && $stable(filter_out_re))
		else $error("result beat changed while stalled");

	// the input side only opens while the pipe can move
	a_ready_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> out_ready || !out_valid)
		else $error("input taken while output stalled");

	// bins beyond the store answer with zeros
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(out_bin) >= NUM_BINS) |-> response_re == '0
			&& response_im == '0 && filter_out_re == '0
			&& filter_out_im == '0 && !clipped)
		else $error("out-of-range bin gave nonzero result");

	// regularizer reads back what was written
	a_reg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_IDX_REG
			|=> paddr[2] != REG_IDX_REG || prdata == $past(pwdata))
		else $error("regularizer readback mismatch");

endmodule

bind correlation_filter_bin_update cfbu_checker #(.NUM_BINS(NUM_BINS)) u_cfbu_checker (.*);

`default_nettype wire
